// File: rtl/rlcseg_pkg.sv
// ---------------------------------------------------------------------------
// rlcseg_pkg
// Shared types and constants for the RLC SDU segmenter.
// ---------------------------------------------------------------------------
package rlcseg_pkg;

	// segment size after reset
	localparam logic [15:0] SEG_MAX_RESET = 16'd128;

	// segmentation info codes, header byte bits 7:6
	localparam logic [1:0] SI_FIRST  = 2'b01;
	localparam logic [1:0] SI_MIDDLE = 2'b11;
	localparam logic [1:0] SI_LAST   = 2'b10;

	// slot of a result within one input word's output run
	localparam logic [1:0] SLOT_SI     = 2'd0;
	localparam logic [1:0] SLOT_SO_HI  = 2'd1;
	localparam logic [1:0] SLOT_SO_LO  = 2'd2;
	localparam logic [1:0] SLOT_DATA   = 2'd3;

	// header in front of the data byte
	typedef enum logic [1:0] {
		HDR_NONE  = 2'd0,
		HDR_ONE   = 2'd1,
		HDR_THREE = 2'd2
	} hdr_kind_t;

	// everything the emitter needs for one input word
	typedef struct packed {
		hdr_kind_t   kind;
		logic [1:0]  si;
		logic [15:0] offset;
		logic [7:0]  data;
		logic        pdu_end;
	} bundle_t;

endpackage

// File: rtl/rlcseg_ctx.sv
// ---------------------------------------------------------------------------
// rlcseg_ctx
// Segmentation context: SDU offset, position in the segment, latched length
// and the segment size register. Works out the header for each byte.
// ---------------------------------------------------------------------------
module rlcseg_ctx (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_wdata,
	input  logic                  take,
	input  logic [7:0]            data_byte,
	input  logic [15:0]           frame_len,
	output rlcseg_pkg::bundle_t   bundle
);

	logic [15:0] seg_cfg_q;
	logic [15:0] sdu_offset_q;
	logic [15:0] seg_pos_q;
	logic [15:0] len_q;

	logic        first;
	logic [15:0] len_eff;
	logic [15:0] pos_eff;
	logic [15:0] seg_max;
	logic [15:0] remaining;
	logic [15:0] pos_inc;
	logic [15:0] off_inc;
	logic        sdu_done;
	logic        seg_done;

	// current byte's view of the context
	always_comb begin
		first     = (sdu_offset_q == 16'd0);
		len_eff   = first ? ((frame_len == 16'd0) ? 16'd1 : frame_len) : len_q;
		pos_eff   = first ? 16'd0 : seg_pos_q;
		seg_max   = (seg_cfg_q == 16'd0) ? 16'd1 : seg_cfg_q;
		remaining = len_eff - sdu_offset_q;
		pos_inc   = pos_eff + 16'd1;
		off_inc   = sdu_offset_q + 16'd1;
		sdu_done  = (off_inc >= len_eff) || (off_inc == 16'd0);
		seg_done  = (pos_inc >= seg_max);
	end

	// header choice and data for the emitter
	always_comb begin
		if (pos_eff != 16'd0) begin
			bundle.kind = rlcseg_pkg::HDR_NONE;
		end else if (len_eff <= seg_max) begin
			bundle.kind = rlcseg_pkg::HDR_ONE;
		end else begin
			bundle.kind = rlcseg_pkg::HDR_THREE;
		end
		if (first) begin
			bundle.si = rlcseg_pkg::SI_FIRST;
		end else if (remaining <= seg_max) begin
			bundle.si = rlcseg_pkg::SI_LAST;
		end else begin
			bundle.si = rlcseg_pkg::SI_MIDDLE;
		end
		bundle.offset  = sdu_offset_q;
		bundle.data    = data_byte;
		bundle.pdu_end = sdu_done || seg_done;
	end

	// segment size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_cfg_q <= rlcseg_pkg::SEG_MAX_RESET;
		end else if (cfg_we) begin
			seg_cfg_q <= cfg_wdata;
		end
	end

	// context update per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sdu_offset_q <= 16'd0;
			seg_pos_q    <= 16'd0;
			len_q        <= 16'd0;
		end else if (take) begin
			len_q        <= len_eff;
			sdu_offset_q <= sdu_done ? 16'd0 : off_inc;
			seg_pos_q    <= (sdu_done || seg_done) ? 16'd0 : pos_inc;
		end
	end

`ifndef SYNTHESIS
	// offset within the SDU never trails the position within the segment
	a_pos_le_off: assert property (@(posedge clk) disable iff (!arst_n)
		seg_pos_q <= sdu_offset_q)
		else $error("segment position beyond SDU offset");

	// a running SDU always has bytes left
	a_off_lt_len: assert property (@(posedge clk) disable iff (!arst_n)
		(sdu_offset_q != 16'd0) |-> (sdu_offset_q < len_q))
		else $error("SDU offset past latched length");
`endif

endmodule

// File: rtl/rlcseg_emit.sv
// ---------------------------------------------------------------------------
// rlcseg_emit
// Result register: holds one word's header and data and sends them out one
// byte per cycle while out_ready is high. Takes the next word as the data byte leaves.
// ---------------------------------------------------------------------------
module rlcseg_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rlcseg_pkg::bundle_t  bundle,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_byte,
	output logic                 is_header,
	output logic                 pdu_end,
	output logic                 run_last
);

	logic                valid_s1;
	logic [1:0]          slot_s1;
	rlcseg_pkg::bundle_t bundle_s1;

	logic out_fire;
	logic at_data;
	logic load;

	assign at_data  = (slot_s1 == rlcseg_pkg::SLOT_DATA);
	assign out_fire = valid_s1 && out_ready;
	assign in_ready = !valid_s1 || (out_fire && at_data);
	assign load     = in_valid && in_ready;

	// control: valid and slot within the run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			slot_s1  <= rlcseg_pkg::SLOT_DATA;
		end else if (load) begin
			valid_s1 <= 1'b1;
			case (bundle.kind)
				rlcseg_pkg::HDR_ONE:   slot_s1 <= rlcseg_pkg::SLOT_SO_LO;
				rlcseg_pkg::HDR_THREE: slot_s1 <= rlcseg_pkg::SLOT_SI;
				default:               slot_s1 <= rlcseg_pkg::SLOT_DATA;
			endcase
		end else if (out_fire) begin
			if (at_data) begin
				valid_s1 <= 1'b0;
			end else begin
				slot_s1 <= slot_s1 + 2'd1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			bundle_s1 <= bundle;
		end
	end

	// output byte select
	always_comb begin
		case (slot_s1)
			rlcseg_pkg::SLOT_SI:    out_byte = {bundle_s1.si, 6'd0};
			rlcseg_pkg::SLOT_SO_HI: out_byte = bundle_s1.offset[15:8];
			rlcseg_pkg::SLOT_SO_LO: out_byte = (bundle_s1.kind == rlcseg_pkg::HDR_THREE) ?
			                                   bundle_s1.offset[7:0] : 8'h00;
			default:                out_byte = bundle_s1.data;
		endcase
	end

	assign out_valid = valid_s1;
	assign is_header = !at_data;
	assign pdu_end   = at_data && bundle_s1.pdu_end;
	assign run_last  = at_data;

`ifndef SYNTHESIS
	// a new word is only loaded once the held run is on its data byte
	a_load_at_data: assert property (@(posedge clk) disable iff (!arst_n)
		(load && valid_s1) |-> at_data)
		else $error("word loaded in the middle of a header");

	// a sent header byte is followed by the next slot of the same run
	a_slot_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && !at_data) |=> (valid_s1 && slot_s1 == $past(slot_s1) + 2'd1))
		else $error("header slot did not advance");
`endif

endmodule

// File: rtl/rlc_sdu_segmenter.sv
// ---------------------------------------------------------------------------
// rlc_sdu_segmenter
// Cuts a byte stream of SDUs into RLC PDUs, inserting a one-byte or
// three-byte segment header ahead of each segment's first data byte.
//
//  channel   dir  tdata                              tuser / tlast
//  s_axis    in   [7:0] data_byte, [23:8] frame_len  -
//  m_axis    out  [7:0] out_byte                     tuser[0] is_header,
//                                                    tuser[1] run_last,
//                                                    tlast pdu_end
//  cfg       in   cfg_wdata = max_segment_bytes      write on cfg_we
//
// A data byte with no header is sent alone, one word a cycle while m_tready
// is high. A segment's first byte follows a one-byte header (whole SDU) or
// a three-byte header (segmented), sent one byte at a time from the single
// result register. A taken word reaches the output in the next cycle.
// Output stalls hold that register and back-pressure the input at the data
// byte. Reset clears the SDU context and loads a segment size of 128.
// ---------------------------------------------------------------------------
module rlc_sdu_segmenter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] data_byte, [23:8] frame_len
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic [1:0]  m_tuser,   // [0] is_header, [1] run_last
	output logic        m_tlast    // pdu_end
);

	rlcseg_pkg::bundle_t bundle;
	logic                take;
	logic                is_header;
	logic                run_last;

	assign take = s_tvalid && s_tready;

	// segmentation context and header choice
	rlcseg_ctx u_ctx (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.take       (take),
		.data_byte  (s_tdata[7:0]),
		.frame_len  (s_tdata[23:8]),
		.bundle     (bundle)
	);

	// result register and byte sequencer
	rlcseg_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.bundle    (bundle),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.is_header (is_header),
		.pdu_end   (m_tlast),
		.run_last  (run_last)
	);

	assign m_tuser = {run_last, is_header};

endmodule

// File: test/rlc_sdu_segmenter_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlc_sdu_segmenter_tb
// Streams SDU bytes into the segmenter under several segment sizes and
// back-pressure patterns. Expected PDU bytes are computed by a local model
// of the segmentation rules and checked in order, field by field.
// ---------------------------------------------------------------------------
module rlc_sdu_segmenter_tb;

	// one SDU byte as sent on the input stream
	typedef struct packed {
		logic [15:0] frame_len;
		logic [7:0]  data_byte;
	} sdu_word_t;

	// one PDU byte as expected on the output stream
	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_header;
		logic       pdu_end;
		logic       run_last;
	} pdu_word_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [15:0] cfg_wdata = 16'd0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = 24'd0;   // [7:0] data_byte, [23:8] frame_len
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;             // [7:0] out_byte
	logic [1:0]  m_tuser;             // [0] is_header, [1] run_last
	logic        m_tlast;             // pdu_end

	sdu_word_t   sdu_words_pending[$];
	pdu_word_t   pdu_words_expected[$];

	// segmentation model state
	logic [15:0] seg_size_reg = rlcseg_pkg::SEG_MAX_RESET;
	logic [15:0] sdu_offset   = 16'd0;
	logic [15:0] seg_pos      = 16'd0;
	logic [15:0] sdu_len      = 16'd0;

	// stimulus bookkeeping
	int          gen_left       = 0;
	int          words_queued   = 0;
	int          src_idle_pct   = 0;
	int          sink_stall_pct = 0;
	int          mismatches     = 0;

	rlc_sdu_segmenter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// Segment one accepted SDU byte and queue the PDU bytes it produces.
	function automatic void segment_byte(input logic [7:0] data, input logic [15:0] len);
		logic [15:0] seg_max;
		logic [15:0] remaining;
		logic [1:0]  si;
		logic        last_of_pdu;
		seg_max = (seg_size_reg == 16'd0) ? 16'd1 : seg_size_reg;
		if (sdu_offset == 16'd0) begin
			sdu_len = (len == 16'd0) ? 16'd1 : len;
			seg_pos = 16'd0;
		end
		// header ahead of the segment's first data byte
		if (seg_pos == 16'd0) begin
			if (sdu_len <= seg_max) begin
				pdu_words_expected.push_back('{8'h00, 1'b1, 1'b0, 1'b0});
			end else begin
				remaining = sdu_len - sdu_offset;
				if (sdu_offset == 16'd0)
					si = rlcseg_pkg::SI_FIRST;
				else if (remaining <= seg_max)
					si = rlcseg_pkg::SI_LAST;
				else
					si = rlcseg_pkg::SI_MIDDLE;
				pdu_words_expected.push_back('{{si, 6'd0}, 1'b1, 1'b0, 1'b0});
				pdu_words_expected.push_back('{sdu_offset[15:8], 1'b1, 1'b0, 1'b0});
				pdu_words_expected.push_back('{sdu_offset[7:0], 1'b1, 1'b0, 1'b0});
			end
		end
		seg_pos    = seg_pos + 16'd1;
		sdu_offset = sdu_offset + 16'd1;
		if (sdu_offset >= sdu_len || sdu_offset == 16'd0) begin
			last_of_pdu = 1'b1;
			sdu_offset  = 16'd0;
			seg_pos     = 16'd0;
		end else if (seg_pos >= seg_max) begin
			last_of_pdu = 1'b1;
			seg_pos     = 16'd0;
		end else begin
			last_of_pdu = 1'b0;
		end
		pdu_words_expected.push_back('{data, 1'b0, last_of_pdu, 1'b1});
	endfunction

	// data bytes lean on 0x00 and 0xFF now and then
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(7);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom_range(255));
	endfunction

	// Start a new SDU and queue its first n bytes; later bytes carry junk lengths.
	task automatic queue_sdu(input logic [15:0] len, input int n);
		int total;
		total = (len == 16'd0) ? 1 : int'(len);
		if (n > total)
			n = total;
		for (int i = 0; i < n; i++)
			sdu_words_pending.push_back('{(i == 0) ? len : 16'($urandom), pick_byte()});
		gen_left     = total - n;
		words_queued = words_queued + n;
	endtask

	// Continue the SDU left open, up to n bytes.
	task automatic queue_rest(input int n);
		if (n > gen_left)
			n = gen_left;
		for (int i = 0; i < n; i++)
			sdu_words_pending.push_back('{16'($urandom), pick_byte()});
		gen_left     = gen_left - n;
		words_queued = words_queued + n;
	endtask

	// Wait until every queued byte is accepted and every PDU byte is out.
	// Checked at the falling edge, once the driver and monitor have settled.
	task automatic drain();
		do
			@(negedge clk);
		while (sdu_words_pending.size() != 0 || s_tvalid || pdu_words_expected.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_seg_size(input logic [15:0] value);
		drain();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we       <= 1'b0;
		seg_size_reg = value;
	endtask

	// One random phase of about n bytes under one segment size.
	task automatic random_phase(input logic [15:0] seg, input int src_pct,
			input int sink_pct, input int n);
		int target;
		int r;
		int len;
		write_seg_size(seg);
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		target         = words_queued + n;
		queue_rest(target - words_queued);
		while (words_queued < target) begin
			r = $urandom_range(99);
			if (r < 5)
				len = 0;
			else if (r < 15)
				len = seg;
			else if (r < 25)
				len = seg + 1;
			else
				len = $urandom_range(1, 3 * seg + 3);
			queue_sdu(16'(len), target - words_queued);
		end
	endtask

	// Input driver: model the byte on acceptance, then offer the next one.
	always @(posedge clk) begin
		sdu_word_t w;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				segment_byte(s_tdata[7:0], s_tdata[23:8]);
			if (!s_tvalid || s_tready) begin
				if (sdu_words_pending.size() != 0 &&
						$urandom_range(99) >= src_idle_pct) begin
					w = sdu_words_pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {w.frame_len, w.data_byte};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: check each accepted word against the oldest expectation.
	always @(posedge clk) begin
		pdu_word_t exp_w;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pdu_words_expected.size() == 0) begin
					report_mismatch($sformatf("unexpected word 0x%02h", m_tdata));
				end else begin
					exp_w = pdu_words_expected.pop_front();
					if (m_tdata !== exp_w.out_byte)
						report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
							m_tdata, exp_w.out_byte));
					if (m_tuser[0] !== exp_w.is_header)
						report_mismatch($sformatf("is_header %b, expected %b",
							m_tuser[0], exp_w.is_header));
					if (m_tlast !== exp_w.pdu_end)
						report_mismatch($sformatf("pdu_end %b, expected %b",
							m_tlast, exp_w.pdu_end));
					if (m_tuser[1] !== exp_w.run_last)
						report_mismatch($sformatf("run_last %b, expected %b",
							m_tuser[1], exp_w.run_last));
				end
			end
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Stimulus sequence
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset segment size: whole SDUs, zero length taken as one
		queue_sdu(16'd1, 1);
		queue_sdu(16'd0, 1);
		queue_sdu(16'd3, 3);

		// first, middle and last segments
		write_seg_size(16'd2);
		queue_sdu(16'd5, 5);

		// zero segment size acts as one
		write_seg_size(16'd0);
		queue_sdu(16'd3, 3);

		// segment size shrinks in the middle of a segment
		write_seg_size(16'd3);
		queue_sdu(16'd7, 4);
		write_seg_size(16'd1);
		queue_rest(3);

		// random phases, preceded by an SDU long enough for a nonzero
		// offset high byte
		write_seg_size(rlcseg_pkg::SEG_MAX_RESET);
		queue_sdu(16'd258, 258);
		random_phase(16'($urandom_range(1, 9)), 0, 0, 12);
		random_phase(16'($urandom_range(1, 9)), 60, 0, 12);
		random_phase(16'($urandom_range(1, 16)), 0, 60, 12);
		random_phase(16'($urandom_range(1, 9)), 35, 35, 12);

		// largest segment size with a full-length SDU, left open at the end
		write_seg_size(16'hFFFF);
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		queue_rest(gen_left);
		queue_sdu(16'hFFFF, 4);

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("rlc_sdu_segmenter test passed");
		else
			$display("rlc_sdu_segmenter test failed");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("rlc_sdu_segmenter test failed");
		$finish;
	end

endmodule
